// ----- design/bda_pkg.sv -----
package bda_pkg;

	localparam int MAX_LEVELS_DEF     = 12;
	localparam int MIN_BLOCK_LOG2_DEF = 6;
	localparam int HEADER_BYTES_DEF   = 16;

	localparam int REQ_W      = 20;
	localparam int ADDR_W     = 18;
	localparam int LVL_OUT_W  = 4;
	localparam int FREE_W     = 18;
	localparam int CFG_W      = 4;
	// command fields are sized for the largest supported pool
	localparam int CMD_LVL_W  = 5;
	localparam int CMD_UNIT_W = 23;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO     = 2'd1,
		ST_NO_SPACE = 2'd2,
		ST_BAD_ADDR = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CMD_ALLOC,
		CMD_RELEASE,
		CMD_REJECT
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t                 op;
		status_t                 status;
		logic [CMD_LVL_W-1:0]    need;
		logic [CMD_UNIT_W-1:0]   unit;
	} cmd_t;

	typedef struct packed {
		status_t               status;
		logic [ADDR_W-1:0]     grant;
		logic [LVL_OUT_W-1:0]  level;
		logic [FREE_W-1:0]     free;
	} res_t;

	typedef enum logic [3:0] {
		B_CLEAR,
		B_IDLE,
		B_WALK_RD,
		B_WALK_CHK,
		B_SPLIT,
		B_REL_RD,
		B_REL_CHK,
		B_BUD_RD,
		B_BUD_CHK,
		B_REL_FIN,
		B_DONE
	} back_state_t;

endpackage

// ----- design/bda_fifo.sv -----
module bda_fifo
	import bda_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic do_push, do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)  rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

// ----- design/bda_front.sv -----
module bda_front
	import bda_pkg::*;
#(
	parameter int MAX_LEVELS     = MAX_LEVELS_DEF,
	parameter int MIN_BLOCK_LOG2 = MIN_BLOCK_LOG2_DEF,
	parameter int HEADER_BYTES   = HEADER_BYTES_DEF,
	parameter int PL_W           = $clog2(MAX_LEVELS + 1)
) (
	input  logic              kind,
	input  logic [REQ_W-1:0]  request_bytes,
	input  logic [ADDR_W-1:0] release_address,
	input  logic [PL_W-1:0]   pool_levels,
	output cmd_t              cmd
);
	localparam int TOT_W = REQ_W + 1;
	localparam int BL_W  = $clog2(TOT_W + 1);
	localparam int CW    = 8;

	logic [TOT_W-1:0]  total, total_m1;
	logic [BL_W-1:0]   bitlen;
	logic              too_big;
	logic [ADDR_W-1:0] off, unit;
	logic              bad_addr;

	always_comb begin
		total    = TOT_W'(request_bytes) + TOT_W'(HEADER_BYTES);
		total_m1 = total - 1'b1;
		bitlen   = '0;
		for (int i = 0; i < TOT_W; i++) begin
			if (total_m1[i]) bitlen = BL_W'(i + 1);
		end
		too_big = CW'(bitlen) > (CW'(MIN_BLOCK_LOG2) + CW'(pool_levels) - CW'(1));
	end

	always_comb begin
		off      = release_address - ADDR_W'(HEADER_BYTES);
		unit     = off >> MIN_BLOCK_LOG2;
		bad_addr = (release_address < ADDR_W'(HEADER_BYTES))
			|| (off[MIN_BLOCK_LOG2-1:0] != '0)
			|| ((unit >> (pool_levels - 1'b1)) != '0);
	end

	always_comb begin
		cmd.unit   = CMD_UNIT_W'(unit);
		cmd.need   = (CW'(bitlen) > CW'(MIN_BLOCK_LOG2))
			? CMD_LVL_W'(CW'(bitlen) - CW'(MIN_BLOCK_LOG2)) : '0;
		cmd.status = ST_OK;
		cmd.op     = CMD_ALLOC;
		if (kind) begin
			cmd.op = CMD_RELEASE;
			if (bad_addr) begin
				cmd.op     = CMD_REJECT;
				cmd.status = ST_BAD_ADDR;
			end
		end else if (request_bytes == '0) begin
			cmd.op     = CMD_REJECT;
			cmd.status = ST_ZERO;
		end else if (too_big) begin
			cmd.op     = CMD_REJECT;
			cmd.status = ST_NO_SPACE;
		end
	end
endmodule

// ----- design/bda_back.sv -----
module bda_back
	import bda_pkg::*;
#(
	parameter int MAX_LEVELS     = MAX_LEVELS_DEF,
	parameter int MIN_BLOCK_LOG2 = MIN_BLOCK_LOG2_DEF,
	parameter int HEADER_BYTES   = HEADER_BYTES_DEF,
	parameter int PL_W           = $clog2(MAX_LEVELS + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [PL_W-1:0] pool_levels,
	input  logic            reinit,
	input  cmd_t            cmd,
	input  logic            cmd_empty,
	output logic            cmd_pop,
	input  logic            res_full,
	output logic            res_push,
	output res_t            res,
	output logic            clearing
);
	localparam int UW     = (MAX_LEVELS > 1) ? MAX_LEVELS - 1 : 1;
	localparam int DEPTH  = 1 << UW;
	localparam int LVL_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int E_W    = LVL_W + 2;
	localparam int FB_W   = MIN_BLOCK_LOG2 + MAX_LEVELS;
	localparam int GW     = FB_W + 8;

	back_state_t state_q, state_d;

	logic [E_W-1:0]   mem [DEPTH];
	logic [E_W-1:0]   rdata_q, wdata;
	logic [UW-1:0]    raddr, waddr;
	logic             we;

	logic [UW:0]      cur_q, clr_q, pool_units, walk_next;
	logic [UW-1:0]    u_q, best_u_q, bud_bit, half_addr;
	logic [LVL_W-1:0] need_q, lev_q, best_lvl_q, top_lvl;
	logic             best_valid_q;
	logic [FB_W-1:0]  fb_q, pool_bytes, need_bytes, e_bytes;
	res_t             res_q;

	logic             e_head, e_used, hit, merge, cur_last;
	logic [LVL_W-1:0] e_lvl;

	assign e_head     = rdata_q[E_W-1];
	assign e_used     = rdata_q[E_W-2];
	assign e_lvl      = rdata_q[LVL_W-1:0];
	assign top_lvl    = LVL_W'(pool_levels - 1'b1);
	assign pool_units = (UW+1)'(1) << top_lvl;
	assign pool_bytes = FB_W'(1) << (MIN_BLOCK_LOG2 + int'(top_lvl));
	assign need_bytes = FB_W'(1) << (MIN_BLOCK_LOG2 + int'(need_q));
	assign e_bytes    = FB_W'(1) << (MIN_BLOCK_LOG2 + int'(e_lvl));
	assign walk_next  = cur_q + ((UW+1)'(1) << e_lvl);
	assign bud_bit    = UW'(1) << lev_q;
	assign half_addr  = u_q + (UW'(1) << (lev_q - 1'b1));
	assign hit        = !e_used && (e_lvl >= need_q)
		&& (!best_valid_q || (e_lvl < best_lvl_q));
	assign merge      = e_head && !e_used && (e_lvl == lev_q);
	assign cur_last   = (clr_q == pool_units - 1'b1);
	assign clearing   = (state_q == B_CLEAR);
	assign res        = res_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_CLEAR:    if (cur_last) state_d = B_IDLE;
			B_IDLE: begin
				if (!cmd_empty && !res_full) begin
					unique case (cmd.op)
						CMD_ALLOC:   state_d = B_WALK_RD;
						CMD_RELEASE: state_d = B_REL_RD;
						default:     state_d = B_DONE;
					endcase
				end
			end
			B_WALK_RD:  state_d = B_WALK_CHK;
			B_WALK_CHK: begin
				if (walk_next >= pool_units)
					state_d = (best_valid_q || hit) ? B_SPLIT : B_DONE;
				else
					state_d = B_WALK_RD;
			end
			B_SPLIT:    if (lev_q == need_q) state_d = B_DONE;
			B_REL_RD:   state_d = B_REL_CHK;
			B_REL_CHK: begin
				if (!e_head || !e_used) state_d = B_DONE;
				else if ((PL_W+1)'(e_lvl) + 1'b1 < (PL_W+1)'(pool_levels))
					state_d = B_BUD_RD;
				else state_d = B_REL_FIN;
			end
			B_BUD_RD:   state_d = B_BUD_CHK;
			B_BUD_CHK: begin
				if (merge && ((PL_W+1)'(lev_q) + 2'd2 < (PL_W+1)'(pool_levels)))
					state_d = B_BUD_RD;
				else state_d = B_REL_FIN;
			end
			B_REL_FIN:  state_d = B_DONE;
			B_DONE:     state_d = B_IDLE;
			default:    state_d = B_IDLE;
		endcase
	end

	// outputs and memory port
	always_comb begin
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		we       = 1'b0;
		waddr    = u_q;
		wdata    = '0;
		raddr    = u_q;
		unique case (state_q)
			B_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q[UW-1:0];
				wdata = (clr_q == '0) ? {1'b1, 1'b0, top_lvl} : '0;
			end
			B_IDLE:    cmd_pop = !cmd_empty && !res_full;
			B_WALK_RD: raddr = cur_q[UW-1:0];
			B_SPLIT: begin
				we = 1'b1;
				if (lev_q == need_q) wdata = {1'b1, 1'b1, need_q};
				else begin
					waddr = half_addr;
					wdata = {1'b1, 1'b0, lev_q - 1'b1};
				end
			end
			B_BUD_RD:  raddr = u_q ^ bud_bit;
			B_BUD_CHK: begin
				we    = merge;
				waddr = u_q | bud_bit;
			end
			B_REL_FIN: begin
				we    = 1'b1;
				wdata = {1'b1, 1'b0, lev_q};
			end
			B_DONE:    res_push = 1'b1;
			default:   ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
			clr_q   <= '0;
		end else if (reinit) begin
			state_q <= B_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == B_CLEAR) clr_q <= cur_last ? '0 : clr_q + 1'b1;
		end
	end

	// datapath; no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			B_CLEAR: fb_q <= pool_bytes;
			B_IDLE: begin
				need_q       <= LVL_W'(cmd.need);
				u_q          <= UW'(cmd.unit);
				cur_q        <= '0;
				best_valid_q <= 1'b0;
				res_q        <= '{cmd.status, '0, '0, FREE_W'(fb_q)};
			end
			B_WALK_CHK: begin
				cur_q <= walk_next;
				if (hit) begin
					best_valid_q <= 1'b1;
					best_lvl_q   <= e_lvl;
					best_u_q     <= cur_q[UW-1:0];
				end
				if (walk_next >= pool_units) begin
					lev_q <= hit ? e_lvl : best_lvl_q;
					u_q   <= hit ? cur_q[UW-1:0] : best_u_q;
					res_q <= '{ST_NO_SPACE, '0, '0, FREE_W'(fb_q)};
				end
			end
			B_SPLIT: begin
				if (lev_q != need_q) lev_q <= lev_q - 1'b1;
				else begin
					fb_q  <= fb_q - need_bytes;
					res_q <= '{ST_OK,
						ADDR_W'((GW'(u_q) << MIN_BLOCK_LOG2) + GW'(HEADER_BYTES)),
						LVL_OUT_W'(need_q), FREE_W'(fb_q - need_bytes)};
				end
			end
			B_REL_CHK: begin
				if (!e_head || !e_used)
					res_q <= '{ST_BAD_ADDR, '0, '0, FREE_W'(fb_q)};
				else begin
					lev_q <= e_lvl;
					fb_q  <= fb_q + e_bytes;
				end
			end
			B_BUD_CHK: begin
				if (merge) begin
					u_q   <= u_q & ~bud_bit;
					lev_q <= lev_q + 1'b1;
				end
			end
			B_REL_FIN: res_q <= '{ST_OK, '0, LVL_OUT_W'(lev_q), FREE_W'(fb_q)};
			default: ;
		endcase
	end

	a_split_above_need: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_SPLIT |-> lev_q >= need_q)
		else $error("split level fell below needed level");
	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> state_q == B_IDLE && !res_full)
		else $error("command taken while busy");
	a_reinit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		reinit |=> state_q == B_CLEAR)
		else $error("reinit did not start clearing");
	a_walk_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_WALK_RD |-> cur_q < pool_units)
		else $error("walk left the pool");
	a_push_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> $past(state_q) != B_IDLE || $past(cmd_pop))
		else $error("result without command");
endmodule

// ----- design/buddy_allocator.sv -----
// Channel  | Handshake           | Payload
// ---------+---------------------+------------------------------------------------
// input    | push / full         | kind, request_bytes, release_address
// result   | pop / empty         | status, grant_address, block_level, free_bytes
// config   | cfg_valid/cfg_ready | cfg_data (pool_levels)
//
// A front stage classifies each beat in its accept cycle and queues a command.
// The back sequencer walks block heads in the unit table (a read and a check state per block),
// then splits down one level at a time or reads buddies to merge (a read and a check state per level).
// After reset and after each config write the table is cleared, one entry a cycle,
// 2^(pool_levels-1) entries, with full held high.
// Two-entry queues on each side let input and result stall independently.
module buddy_allocator
	import bda_pkg::*;
#(
	parameter int MAX_LEVELS     = MAX_LEVELS_DEF,
	parameter int MIN_BLOCK_LOG2 = MIN_BLOCK_LOG2_DEF,
	parameter int HEADER_BYTES   = HEADER_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              kind,
	input  logic [REQ_W-1:0]  request_bytes,
	input  logic [ADDR_W-1:0] release_address,
	output logic              empty,
	input  logic              pop,
	output logic [1:0]        status,
	output logic [ADDR_W-1:0] grant_address,
	output logic [LVL_OUT_W-1:0] block_level,
	output logic [FREE_W-1:0] free_bytes,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_W-1:0]  cfg_data
);
	localparam int PL_W = $clog2(MAX_LEVELS + 1);
	localparam int CMP_W = (PL_W > CFG_W) ? PL_W : CFG_W;

	logic [PL_W-1:0] pool_levels_q;
	logic            cfg_wr, cmd_full, cmd_empty, cmd_pop, res_full, res_push, clearing;
	cmd_t            cmd_in, cmd_out;
	res_t            res_in, res_out;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// clamp the written level count into 1..MAX_LEVELS
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pool_levels_q <= PL_W'(MAX_LEVELS);
		else if (cfg_wr) begin
			if (cfg_data == '0) pool_levels_q <= PL_W'(1);
			else if (CMP_W'(cfg_data) > CMP_W'(MAX_LEVELS)) pool_levels_q <= PL_W'(MAX_LEVELS);
			else pool_levels_q <= PL_W'(cfg_data);
		end
	end

	// hold off input while the table is being cleared
	assign full = cmd_full || clearing;

	bda_front #(
		.MAX_LEVELS(MAX_LEVELS), .MIN_BLOCK_LOG2(MIN_BLOCK_LOG2),
		.HEADER_BYTES(HEADER_BYTES), .PL_W(PL_W)
	) u_front (
		.kind(kind), .request_bytes(request_bytes), .release_address(release_address),
		.pool_levels(pool_levels_q), .cmd(cmd_in)
	);

	bda_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(QUEUE_DEPTH)) u_cmd_q (
		.clk(clk), .arst_n(arst_n), .push(push && !full), .wdata(cmd_in),
		.pop(cmd_pop), .rdata(cmd_out), .full(cmd_full), .empty(cmd_empty)
	);

	bda_back #(
		.MAX_LEVELS(MAX_LEVELS), .MIN_BLOCK_LOG2(MIN_BLOCK_LOG2),
		.HEADER_BYTES(HEADER_BYTES), .PL_W(PL_W)
	) u_back (
		.clk(clk), .arst_n(arst_n), .pool_levels(pool_levels_q), .reinit(cfg_wr),
		.cmd(cmd_out), .cmd_empty(cmd_empty), .cmd_pop(cmd_pop),
		.res_full(res_full), .res_push(res_push), .res(res_in), .clearing(clearing)
	);

	bda_fifo #(.WIDTH($bits(res_t)), .DEPTH(QUEUE_DEPTH)) u_res_q (
		.clk(clk), .arst_n(arst_n), .push(res_push), .wdata(res_in),
		.pop(pop), .rdata(res_out), .full(res_full), .empty(empty)
	);

	assign status        = res_out.status;
	assign grant_address = res_out.grant;
	assign block_level   = res_out.level;
	assign free_bytes    = res_out.free;
endmodule

// ----- dv/buddy_allocator_tb.sv -----
`timescale 1ns / 1ps

module buddy_allocator_tb;
	import bda_pkg::*;

	localparam bit OP_ALLOC   = 1'b0;
	localparam bit OP_RELEASE = 1'b1;
	localparam int UNITS_MAX  = 1 << (MAX_LEVELS_DEF - 1);
	localparam int UNIT_LOG2  = MIN_BLOCK_LOG2_DEF;
	localparam int HDR        = HEADER_BYTES_DEF;

	// one beat on the input side
	typedef struct {
		bit              kind;
		bit [REQ_W-1:0]  req;
		bit [ADDR_W-1:0] addr;
	} alloc_op_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic kind = 1'b0;
	logic [REQ_W-1:0] request_bytes = '0;
	logic [ADDR_W-1:0] release_address = '0;
	logic pop = 1'b0;
	logic cfg_valid = 1'b0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic full, empty, cfg_ready;
	logic [1:0] status;
	logic [ADDR_W-1:0] grant_address;
	logic [LVL_OUT_W-1:0] block_level;
	logic [FREE_W-1:0] free_bytes;

	buddy_allocator u_dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .kind(kind),
		.request_bytes(request_bytes), .release_address(release_address),
		.empty(empty), .pop(pop),
		.status(status), .grant_address(grant_address),
		.block_level(block_level), .free_bytes(free_bytes),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Shadow allocator state: unit table, free count and pool size.
	// ---------------------------------------------------------------
	bit       unit_head [UNITS_MAX];
	bit [3:0] unit_lvl  [UNITS_MAX];
	bit       unit_busy [UNITS_MAX];
	int unsigned pool_lv;
	int unsigned free_cnt;

	alloc_op_t   pending_ops[$];
	res_t        expected_res[$];
	bit [ADDR_W-1:0] live_grants[$];  // addresses that can legally be released

	int n_in, n_out, n_cfg, n_mism, n_ok, n_nospace, n_badrel;
	int send_idle_pct, recv_idle_pct;
	int hold_req, hold_left;
	bit beat_taken;

	// Rebuild the table as one free block of the top level.
	function automatic void clear_pool(int unsigned lv);
		for (int i = 0; i < UNITS_MAX; i++) begin
			unit_head[i] = 1'b0;
			unit_lvl[i]  = '0;
			unit_busy[i] = 1'b0;
		end
		pool_lv = lv;
		unit_head[0] = 1'b1;
		unit_lvl[0]  = 4'(lv - 1);
		free_cnt = (1 << (lv - 1)) << UNIT_LOG2;
		live_grants.delete();
	endfunction

	// Work out the result of one accepted beat and update the shadow table.
	function automatic void predict_grant(bit k, bit [REQ_W-1:0] rq, bit [ADDR_W-1:0] ad);
		res_t r;
		int unsigned units, total, kk, need, lv, u, st, half, buddy, off;
		bit found, bad;
		r = '0;
		r.status = ST_OK;
		units = 1 << (pool_lv - 1);
		if (k == OP_ALLOC) begin
			total = rq + HDR;
			if (rq == 0)
				r.status = ST_ZERO;
			else if (total > (units << UNIT_LOG2))
				r.status = ST_NO_SPACE;
			else begin
				kk = 0;
				while ((1 << kk) < total) kk++;
				need = (kk > UNIT_LOG2) ? kk - UNIT_LOG2 : 0;
				found = 1'b0;
				st = 0;
				// smallest level first, lowest address within a level
				for (lv = need; lv < pool_lv && !found; lv++)
					for (u = 0; u < units; u++)
						if (unit_head[u] && !unit_busy[u] && unit_lvl[u] == lv) begin
							st = u;
							found = 1'b1;
							break;
						end
				if (!found)
					r.status = ST_NO_SPACE;
				else begin
					// split down, upper halves become free blocks
					lv = unit_lvl[st];
					while (lv > need) begin
						half = st + (1 << (lv - 1));
						lv--;
						unit_head[half] = 1'b1;
						unit_busy[half] = 1'b0;
						unit_lvl[half]  = 4'(lv);
					end
					unit_lvl[st]  = 4'(need);
					unit_busy[st] = 1'b1;
					free_cnt -= (1 << need) << UNIT_LOG2;
					r.grant = ADDR_W'((st << UNIT_LOG2) + HDR);
					r.level = LVL_OUT_W'(need);
					live_grants.push_back(r.grant);
				end
			end
		end else begin
			bad = 1'b0;
			u = 0;
			if (ad < HDR)
				bad = 1'b1;
			else begin
				off = ad - HDR;
				if (off[UNIT_LOG2-1:0] != 0)
					bad = 1'b1;
				else begin
					u = off >> UNIT_LOG2;
					if (u >= units || !unit_head[u] || !unit_busy[u])
						bad = 1'b1;
				end
			end
			if (bad)
				r.status = ST_BAD_ADDR;
			else begin
				lv = unit_lvl[u];
				unit_busy[u] = 1'b0;
				free_cnt += (1 << lv) << UNIT_LOG2;
				// merge with free buddies of equal level
				while (lv + 1 < pool_lv) begin
					buddy = u ^ (1 << lv);
					if (!unit_head[buddy] || unit_busy[buddy] || unit_lvl[buddy] != lv)
						break;
					unit_head[buddy] = 1'b0;
					unit_lvl[buddy]  = '0;
					unit_head[u] = 1'b0;
					unit_lvl[u]  = '0;
					u &= ~(1 << lv);
					lv++;
					unit_head[u] = 1'b1;
					unit_busy[u] = 1'b0;
					unit_lvl[u]  = 4'(lv);
				end
				r.level = LVL_OUT_W'(lv);
			end
		end
		r.free = FREE_W'(free_cnt);
		case (r.status)
			ST_OK:       n_ok++;
			ST_NO_SPACE: n_nospace++;
			ST_BAD_ADDR: n_badrel++;
			default: ;
		endcase
		expected_res.push_back(r);
	endfunction

	function automatic void note_mismatch(string msg);
		n_mism++;
		if (n_mism <= 10)
			$display("mismatch at %0t: %s", $realtime, msg);
	endfunction

	// ---------------------------------------------------------------
	// Driver: present the oldest pending beat at the falling edge.
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n || pending_ops.size() == 0)
			push <= 1'b0;
		else if ((push && !beat_taken) || $urandom_range(0, 99) >= send_idle_pct) begin
			// hold an offered beat until taken; otherwise offer the next one
			push            <= 1'b1;
			kind            <= pending_ops[0].kind;
			request_bytes   <= pending_ops[0].req;
			release_address <= pending_ops[0].addr;
		end else
			push <= 1'b0;
		beat_taken = 1'b0;
	end

	// Accept at the rising edge and predict in acceptance order.
	always @(posedge clk) begin
		alloc_op_t it;
		if (arst_n && push && !full) begin
			it = pending_ops.pop_front();
			predict_grant(it.kind, it.req, it.addr);
			beat_taken = 1'b1;
			n_in++;
		end
	end

	// ---------------------------------------------------------------
	// Monitor: random stalls, long hold-off on request, field checks.
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (!arst_n)
			pop <= 1'b0;
		else if (hold_left > 0) begin
			pop <= 1'b0;
			hold_left--;
		end else
			pop <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		res_t e;
		if (arst_n && pop && !empty) begin
			n_out++;
			if (expected_res.size() == 0)
				note_mismatch($sformatf("unexpected result status=%0d grant=%0d lvl=%0d free=%0d",
					status, grant_address, block_level, free_bytes));
			else begin
				e = expected_res.pop_front();
				if (status != e.status || grant_address != e.grant ||
				    block_level != e.level || free_bytes != e.free)
					note_mismatch($sformatf(
						"exp st=%0d grant=%0d lvl=%0d free=%0d, got st=%0d grant=%0d lvl=%0d free=%0d",
						e.status, e.grant, e.level, e.free,
						status, grant_address, block_level, free_bytes));
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	task automatic queue_op(bit k, int unsigned rq, int unsigned ad);
		alloc_op_t it;
		it.kind = k;
		it.req  = REQ_W'(rq);
		it.addr = ADDR_W'(ad);
		pending_ops.push_back(it);
	endtask

	task automatic wait_sent();
		while (pending_ops.size() != 0) @(posedge clk);
	endtask

	// Hold the sender until every expected result has come back.
	task automatic drain();
		wait_sent();
		while (expected_res.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_levels(bit [CFG_W-1:0] v);
		int unsigned lv;
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		// out-of-range writes clamp to the legal range
		lv = (v < 1) ? 1 : (v > MAX_LEVELS_DEF) ? MAX_LEVELS_DEF : v;
		clear_pool(lv);
		n_cfg++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random mix: mostly real alloc/release traffic, some noise.
	task automatic random_phase(int count);
		int unsigned pool, shift, maxsh, rq, idx, pick;
		int i;
		i = 0;
		while (i < count) begin
			for (int b = 0; b < 6 && i < count; b++, i++) begin
				pool = (1 << (pool_lv - 1)) << UNIT_LOG2;
				pick = $urandom_range(0, 99);
				if (pick < 52) begin
					// large pools get large requests so the head walk stays short
					maxsh = (pool_lv >= 10) ? 4 : pool_lv;
					shift = $urandom_range(0, maxsh);
					rq = $urandom_range(1, (pool >> shift) > HDR ? (pool >> shift) - HDR : 1);
					queue_op(OP_ALLOC, rq, $urandom_range(0, (1 << ADDR_W) - 1));
				end else if (pick < 56)
					queue_op(OP_ALLOC, 0, $urandom_range(0, (1 << ADDR_W) - 1));
				else if (pick < 60)
					queue_op(OP_ALLOC, $urandom_range(0, (1 << REQ_W) - 1),
						$urandom_range(0, (1 << ADDR_W) - 1));
				else if (pick < 90 && live_grants.size() > 0) begin
					idx = $urandom_range(0, live_grants.size() - 1);
					queue_op(OP_RELEASE, $urandom_range(0, (1 << REQ_W) - 1), live_grants[idx]);
					live_grants.delete(idx);
				end else
					queue_op(OP_RELEASE, $urandom_range(0, (1 << REQ_W) - 1),
						$urandom_range(0, (1 << ADDR_W) - 1));
			end
			wait_sent();
		end
	endtask

	task automatic set_idling(int mode);
		case (mode % 4)
			0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
			1: begin send_idle_pct = 64; recv_idle_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_idle_pct = 64; end
			default: begin send_idle_pct = 38; recv_idle_pct = 38; end
		endcase
	endtask

	initial begin
		bit [CFG_W-1:0] lv_plan[10];
		int cnt_plan[10];
		lv_plan  = '{4'd1, 4'd0, 4'd15, 4'd4, 4'd6, 4'd8, 4'd3, 4'd5, 4'd7, 4'd12};
		cnt_plan = '{20, 20, 30, 130, 130, 130, 110, 130, 130, 60};
		n_in = 0; n_out = 0; n_cfg = 0; n_mism = 0;
		n_ok = 0; n_nospace = 0; n_badrel = 0;
		hold_req = 0; hold_left = 0; beat_taken = 1'b0;
		set_idling(0);
		clear_pool(MAX_LEVELS_DEF);
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed checks on the reset pool
		queue_op(OP_ALLOC, 0, 0);                    // zero-size request
		queue_op(OP_ALLOC, (1 << REQ_W) - 1, 0);     // far too large
		queue_op(OP_ALLOC, 1, 0);                    // smallest block
		queue_op(OP_ALLOC, 64 - HDR, 0);             // exactly one unit
		queue_op(OP_ALLOC, 64 - HDR + 1, 0);         // just over one unit
		queue_op(OP_ALLOC, (1 << 17) - HDR, 0);      // whole pool, no room now
		queue_op(OP_RELEASE, 0, 0);                  // below header
		queue_op(OP_RELEASE, 0, HDR + 1);            // not unit aligned
		queue_op(OP_RELEASE, 0, (1 << 17) + HDR);    // beyond the pool
		queue_op(OP_RELEASE, 0, (1 << ADDR_W) - 1);  // all ones
		queue_op(OP_RELEASE, 0, HDR + 3 * 64);       // not a block start
		queue_op(OP_RELEASE, 0, HDR + 2 * 64);       // good release
		queue_op(OP_RELEASE, 0, HDR + 2 * 64);       // already free
		queue_op(OP_RELEASE, 0, HDR);
		queue_op(OP_RELEASE, 0, HDR + 64);           // merges to the top
		queue_op(OP_ALLOC, (1 << 17) - HDR, 0);      // whole pool fits
		queue_op(OP_ALLOC, 1, 0);                    // nothing left
		queue_op(OP_RELEASE, 0, HDR);
		drain();

		for (int p = 0; p < 10; p++) begin
			write_levels(lv_plan[p]);
			set_idling(p);
			if (p == 4) begin
				// long receiver hold-off while the sender keeps offering
				hold_req = 400;
				random_phase(12);
				drain();             // sender pause until all results are in
				random_phase(cnt_plan[p] - 12);
			end else
				random_phase(cnt_plan[p]);
		end

		drain();
		repeat (50) @(posedge clk);
		$display("Covered %0d beats in, %0d results, %0d pool settings (1 to 12 levels).",
			n_in, n_out, n_cfg);
		$display("Outcomes: %0d ok, %0d no space, %0d bad release, %0d mismatches.",
			n_ok, n_nospace, n_badrel, n_mism);
		if (n_mism == 0 && expected_res.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#100ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/bda_pkg.sv
design/bda_fifo.sv
design/bda_front.sv
design/bda_back.sv
design/buddy_allocator.sv
dv/buddy_allocator_tb.sv
